// ===== src/skt_pkg.sv =====
// Shared constants, codes and the cell control struct of the sorted key table.
package skt_pkg;

    // Configuration defaults
    localparam int DEPTH_DEF         = 64;
    localparam int MAX_KEY_BYTES_DEF = 8;

    // Fixed field widths
    localparam int OP_W     = 2;
    localparam int KEY_IN_W = 64;
    localparam int LEN_W    = 4;
    localparam int STATUS_W = 3;
    localparam int IN_W     = 72;   // op + key_bytes + key_length, padded to bytes

    // Operation codes
    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_FIND   = 2'd1;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd3;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd4;

    // Control broadcast to every cell
    typedef struct packed {
        logic cmp;   // compare the stored entry against the search key
        logic ins;   // open a gap at the lower bound and write the new key
        logic rem;   // close the gap at the lower bound
    } skt_ctrl_t;

endpackage

// ===== src/skt_cell.sv =====
// One table cell: holds an entry, compares it to the search key, shifts with its neighbors.
module skt_cell
    import skt_pkg::*;
#(
    parameter int KEY_W = 8 * MAX_KEY_BYTES_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  skt_ctrl_t        ctrl,
    input  logic             cell_valid,
    input  logic [KEY_W-1:0] new_key,
    input  logic [LEN_W-1:0] new_len,
    input  logic             prev_lt,
    input  logic [KEY_W-1:0] prev_key,
    input  logic [LEN_W-1:0] prev_len,
    input  logic [KEY_W-1:0] next_key,
    input  logic [LEN_W-1:0] next_len,
    output logic             lt,
    output logic             eq,
    output logic [KEY_W-1:0] key,
    output logic [LEN_W-1:0] len
);

    logic             lt_reg;
    logic             lt_next;
    logic             eq_reg;
    logic             eq_next;
    logic [KEY_W-1:0] key_reg;
    logic [KEY_W-1:0] key_next;
    logic [LEN_W-1:0] len_reg;
    logic [LEN_W-1:0] len_next;

    // Zero-padded keys order correctly when the length is appended as the least significant part.
    always_comb
    begin
        lt_next = lt_reg;
        eq_next = eq_reg;
        if (ctrl.cmp)
        begin
            lt_next = cell_valid && ({key_reg, len_reg} < {new_key, new_len});
            eq_next = cell_valid && ({key_reg, len_reg} == {new_key, new_len});
        end
    end

    always_comb
    begin
        key_next = key_reg;
        len_next = len_reg;
        if (ctrl.ins && !lt_reg)
        begin
            if (prev_lt)
            begin
                key_next = new_key;
                len_next = new_len;
            end
            else
            begin
                key_next = prev_key;
                len_next = prev_len;
            end
        end
        else if (ctrl.rem && !lt_reg)
        begin
            key_next = next_key;
            len_next = next_len;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lt_reg <= 1'b0;
            eq_reg <= 1'b0;
        end
        else
        begin
            lt_reg <= lt_next;
            eq_reg <= eq_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        len_reg <= len_next;
    end

    assign lt  = lt_reg;
    assign eq  = eq_reg;
    assign key = key_reg;
    assign len = len_reg;

endmodule

// ===== src/skt_locate.sv =====
// Turns the row of below-key flags into the lower-bound slot and an equal-key hit.
module skt_locate
    import skt_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic [DEPTH-1:0]         lt,
    input  logic [DEPTH-1:0]         eq,
    output logic [$clog2(DEPTH)-1:0] pos,
    output logic                     found
);

    localparam int IDX_W = $clog2(DEPTH);

    logic [DEPTH-1:0] edge_hit;
    logic [IDX_W-1:0] pos_reg;
    logic [IDX_W-1:0] pos_next;
    logic             found_reg;
    logic             found_next;

    // The flags form a thermometer; mark the first cell that is not below the key.
    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            if (i == 0)
                edge_hit[i] = !lt[i];
            else
                edge_hit[i] = !lt[i] && lt[i-1];
        end
    end

    always_comb
    begin
        pos_next = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (edge_hit[i])
                pos_next = pos_next | IDX_W'(i);
        end
        found_next = |(edge_hit & eq);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            found_reg <= 1'b0;
        end
        else
        begin
            pos_reg   <= pos_next;
            found_reg <= found_next;
        end
    end

    assign pos   = pos_reg;
    assign found = found_reg;

endmodule

// ===== src/sorted_key_table.sv =====
// Top level of the sorted key table: controller, row of cells and result register.
//
//  channel | dir | tdata fields (lowest bit up)                      | tuser
//  s_*     | in  | op[1:0], key_bytes[65:2], key_length[69:66]       | -
//  m_*     | out | status[2:0], slot, entries_used                   | -
//
// Each item steps through accept, compare in every cell, lower-bound
// encode and update. The shift of the row on insert or remove happens in the
// update cycle, all cells at once. Reset empties the table; entries are not
// cleared. A result waiting on m_tready does not block the next accept; the
// update cycle of that next item holds until the result register is free.
module sorted_key_table
    import skt_pkg::*;
#(
    parameter int DEPTH         = DEPTH_DEF,
    parameter int MAX_KEY_BYTES = MAX_KEY_BYTES_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [IN_W-1:0]     s_tdata,    // op, key_bytes, key_length, zero pad
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [((STATUS_W + $clog2(DEPTH) + $clog2(DEPTH+1) + 7) / 8) * 8 - 1:0]
                                m_tdata     // status, slot, entries_used, zero pad
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int KEY_W = 8 * MAX_KEY_BYTES;
    localparam int OUT_W = ((STATUS_W + IDX_W + CNT_W + 7) / 8) * 8;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CMP  = 2'd1;
    localparam logic [1:0] S_LOC  = 2'd2;
    localparam logic [1:0] S_UPD  = 2'd3;

    logic [1:0]          state_reg;
    logic [1:0]          state_next;
    logic [OP_W-1:0]     op_reg;
    logic [KEY_W-1:0]    key_reg;
    logic [LEN_W-1:0]    len_reg;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic                out_valid_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [STATUS_W-1:0] status_next;
    logic [IDX_W-1:0]    slot_reg;
    logic [IDX_W-1:0]    slot_next;

    logic [OP_W-1:0]     in_op;
    logic [KEY_IN_W-1:0] in_key;
    logic [LEN_W-1:0]    in_len;
    logic [LEN_W-1:0]    len_sat;
    logic [KEY_W-1:0]    key_norm;

    logic                accept;
    logic                upd_fire;
    logic                full;
    skt_ctrl_t           ctrl;

    logic [DEPTH-1:0]    cell_lt;
    logic [DEPTH-1:0]    cell_eq;
    logic [KEY_W-1:0]    cell_key [DEPTH];
    logic [LEN_W-1:0]    cell_len [DEPTH];
    logic [IDX_W-1:0]    pos;
    logic                found;

    assign in_op  = s_tdata[OP_W-1:0];
    assign in_key = s_tdata[OP_W +: KEY_IN_W];
    assign in_len = s_tdata[OP_W + KEY_IN_W +: LEN_W];

    // Saturate the length and drop bytes past it.
    always_comb
    begin
        len_sat = (in_len > LEN_W'(MAX_KEY_BYTES)) ? LEN_W'(MAX_KEY_BYTES) : in_len;
        for (int b = 0; b < MAX_KEY_BYTES; b++)
        begin
            if (LEN_W'(b) < len_sat)
                key_norm[KEY_W-1-8*b -: 8] = in_key[KEY_IN_W-1-8*b -: 8];
            else
                key_norm[KEY_W-1-8*b -: 8] = 8'h00;
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign upd_fire = (state_reg == S_UPD) && (!out_valid_reg || m_tready);
    assign full     = (count_reg == CNT_W'(DEPTH));

    always_comb
    begin
        ctrl.cmp = (state_reg == S_CMP);
        ctrl.ins = upd_fire && (op_reg == OP_INSERT) && !found && !full;
        ctrl.rem = upd_fire && (op_reg == OP_REMOVE) && found;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: if (accept) state_next = S_CMP;
            S_CMP:  state_next = S_LOC;
            S_LOC:  state_next = S_UPD;
            S_UPD:  if (upd_fire) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        status_next = ST_NOT_FOUND;
        slot_next   = '0;
        count_next  = count_reg;
        case (op_reg)
            OP_INSERT:
            begin
                if (found)
                begin
                    status_next = ST_DUPLICATE;
                    slot_next   = pos;
                end
                else if (full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    status_next = ST_INSERTED;
                    slot_next   = pos;
                    count_next  = count_reg + 1'b1;
                end
            end
            OP_FIND:
            begin
                if (found)
                begin
                    status_next = ST_FOUND;
                    slot_next   = pos;
                end
            end
            OP_REMOVE:
            begin
                if (found)
                begin
                    status_next = ST_FOUND;
                    slot_next   = pos;
                    count_next  = count_reg - 1'b1;
                end
            end
            OP_CLEAR:
            begin
                status_next = ST_FOUND;
                count_next  = '0;
            end
            default:
            begin
                status_next = ST_NOT_FOUND;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (upd_fire)
                count_reg <= count_next;
            if (upd_fire)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg  <= in_op;
            key_reg <= key_norm;
            len_reg <= len_sat;
        end
        if (upd_fire)
        begin
            status_reg <= status_next;
            slot_reg   <= slot_next;
        end
    end

    // Row of cells; the first cell sees a virtual below-key neighbor, the last holds on remove.
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic             prev_lt;
        logic [KEY_W-1:0] prev_key;
        logic [LEN_W-1:0] prev_len;
        logic [KEY_W-1:0] next_key;
        logic [LEN_W-1:0] next_len;

        if (i == 0)
        begin : g_first
            assign prev_lt  = 1'b1;
            assign prev_key = key_reg;
            assign prev_len = len_reg;
        end
        else
        begin : g_inner
            assign prev_lt  = cell_lt[i-1];
            assign prev_key = cell_key[i-1];
            assign prev_len = cell_len[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign next_key = cell_key[i];
            assign next_len = cell_len[i];
        end
        else
        begin : g_body
            assign next_key = cell_key[i+1];
            assign next_len = cell_len[i+1];
        end

        skt_cell #(
            .KEY_W (KEY_W)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .cell_valid (CNT_W'(i) < count_reg),
            .new_key    (key_reg),
            .new_len    (len_reg),
            .prev_lt    (prev_lt),
            .prev_key   (prev_key),
            .prev_len   (prev_len),
            .next_key   (next_key),
            .next_len   (next_len),
            .lt         (cell_lt[i]),
            .eq         (cell_eq[i]),
            .key        (cell_key[i]),
            .len        (cell_len[i])
        );
    end

    skt_locate #(
        .DEPTH (DEPTH)
    ) u_locate (
        .clk   (clk),
        .rst_n (rst_n),
        .lt    (cell_lt),
        .eq    (cell_eq),
        .pos   (pos),
        .found (found)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_W'({count_reg, slot_reg, status_reg});

    // Checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count above table depth");

    a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !upd_fire |=> $stable(count_reg))
        else $error("entry count changed outside an update");

    a_full_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && status_reg == ST_FULL) |-> full)
        else $error("full status reported on a table that is not full");

    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (upd_fire && op_reg == OP_CLEAR) |=> (count_reg == '0))
        else $error("clear left entries in the table");

endmodule
